>>> src/radial_falloff_height_map_defines.svh
// assertion macros for the radial falloff height map block
`ifndef RADIAL_FALLOFF_HEIGHT_MAP_DEFINES_SVH
`define RADIAL_FALLOFF_HEIGHT_MAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define RFHM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// checked on every edge, reset included
`define RFHM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define RFHM_ASSERT(lbl, prop, msg)
`define RFHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/rfhm_pkg.sv
package rfhm_pkg;

   // field and register widths
   localparam int unsigned MAP_W        = 9;
   localparam int unsigned MAP_SIZE_MAX = 511;
   localparam int unsigned COEF_W       = 16;
   localparam int unsigned IDX_W        = 16;
   localparam int unsigned HIN_W        = 20;
   localparam int unsigned HOUT_W       = 17;
   localparam int unsigned FAL_W        = 20;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 16;

   localparam int unsigned DEF_MAX_MAP_SIZE = 256;

   // register reset values
   localparam logic [MAP_W-1:0]  MAP_SIZE_RST   = 9'd256;
   localparam logic [COEF_W-1:0] EXPONENT_A_RST = 16'd12288;
   localparam logic [COEF_W-1:0] SHAPE_B_RST    = 16'd9011;
   localparam logic [COEF_W-1:0] SCALE_C_RST    = 16'd4096;

   localparam logic [FAL_W-1:0] FAL_MAX = 20'hFFFFF;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_SIZE   = 2'd0,
      CSR_EXPONENT_A = 2'd1,
      CSR_SHAPE_B    = 2'd2,
      CSR_SCALE_C    = 2'd3
   } csr_idx_type;

   // stage plan
   localparam int unsigned DIV1_PER    = 4;
   localparam int unsigned DIV1_FIRST  = 1;
   localparam int unsigned GEO_STG     = DIV1_FIRST + 16 / DIV1_PER;
   localparam int unsigned DIV2_PER    = 4;
   localparam int unsigned DIV2_FIRST  = GEO_STG + 1;
   localparam int unsigned SQRT_PER    = 4;
   localparam int unsigned SQRT_FIRST  = DIV2_FIRST + 32 / DIV2_PER;
   localparam int unsigned Q_STG       = SQRT_FIRST + 16 / SQRT_PER;
   localparam int unsigned NORM_STG    = Q_STG + 1;
   localparam int unsigned LOG_FIRST   = NORM_STG + 1;
   localparam int unsigned SCALE_STG   = LOG_FIRST + 16;
   localparam int unsigned D_STG       = SCALE_STG + 1;
   localparam int unsigned EXP_FIRST   = D_STG + 1;
   localparam int unsigned DEN_STG     = EXP_FIRST + 16;
   localparam int unsigned DIV3_PER    = 2;
   localparam int unsigned DIV3_FIRST  = DEN_STG + 1;
   localparam int unsigned FIN_STG     = DIV3_FIRST + 20 / DIV3_PER;
   localparam int unsigned NSTG        = FIN_STG;

   typedef struct packed {
      logic [MAP_W-1:0]  n;
      logic [17:0]       nsq;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
   } cfg_type;

   typedef struct packed {
      logic [15:0]              num;
      logic [8:0]               rem1;
      logic [15:0]              quo1;
      logic signed [HIN_W-1:0]  h;
      logic                     far;
      logic [17:0]              rem2;
      logic [31:0]              xq;
      logic [15:0]              root;
      logic [17:0]              rrem;
      logic [15:0]              v;
      logic [19:0]              q;
      logic                     a_zero;
      logic                     f_zero;
      logic                     q_zero;
      logic [4:0]               pq;
      logic [4:0]               pv;
      logic [30:0]              mq;
      logic [30:0]              mv;
      logic [15:0]              fq;
      logic [15:0]              fv;
      logic signed [26:0]       sq;
      logic signed [26:0]       sv;
      logic signed [11:0]       di;
      logic [15:0]              df;
      logic                     big;
      logic [30:0]              er;
      logic [51:0]              den;
      logic                     sat;
      logic                     zero;
      logic [51:0]              rem3;
      logic [19:0]              quo3;
      logic [FAL_W-1:0]         fval;
      logic [HOUT_W-1:0]        hout;
   } pipe_type;

   typedef struct packed {
      logic [HOUT_W-1:0] hout;
      logic [FAL_W-1:0]  fval;
   } out_type;

   // 2^(2^-k) factors, Q1.30, k = 1..16 at index k-1
   typedef logic [15:0][30:0] exp_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = x;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] cur;
      cur = 64'd1 << 31;
      for (int k = 0; k < 16; k++) begin
         cur    = isqrt64(cur << 30);
         tab[k] = cur[30:0];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

>>> src/radial_falloff_height_map.sv
// radial falloff height map
// req channel: one word per height-map cell, raster index and signed Q3.16
// height; req_valid with req_stall from this block.
// rsp channel: one word per cell, falloff in Q4.16 (saturated) and the
// height minus falloff clamped to [0,1] in Q1.16; rsp_stall from the sink.
// csr port: csr_we writes csr_wdata into the register at csr_index
// (map size, exponent, shape, scale); write only while the block is empty.
// throughput: one word per clock while req_stall is low. words pass the
// stages in order: index divider, distance divider,
// square root, two 16-step log2 squaring chains, a 16-step exp2 product
// chain and the final reciprocal divider, then the output register.
// all stages move on one enable; a one-word skid behind the output register
// lets one more word in while the output stalls, then req_stall rises
// until the output is taken.
// reset (synchronous) empties the pipeline and restores register defaults.
`include "radial_falloff_height_map_defines.svh"

module radial_falloff_height_map
   import rfhm_pkg::*;
#(
   parameter int unsigned MAX_MAP_SIZE = DEF_MAX_MAP_SIZE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IDX_W-1:0]      req_cell_index,
   input  logic signed [HIN_W-1:0] req_height_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HOUT_W-1:0]     rsp_height_out,
   output logic [FAL_W-1:0]      rsp_falloff_value,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned NCAP_I = (MAX_MAP_SIZE < MAP_SIZE_MAX) ? MAX_MAP_SIZE : MAP_SIZE_MAX;
   localparam logic [MAP_W-1:0] N_CAP = MAP_W'(NCAP_I);

   logic [MAP_W-1:0]  map_size_ff;
   logic [COEF_W-1:0] exponent_a_ff;
   logic [COEF_W-1:0] shape_b_ff;
   logic [COEF_W-1:0] scale_c_ff;
   logic [17:0]       nsq_ff;
   logic [17:0]       nsq_in;
   logic [MAP_W-1:0]  n_eff;
   cfg_type           cfg;

   pipe_type          pipe_ff [0:NSTG-1];
   pipe_type          pipe_in [1:NSTG];
   pipe_type          head_in;
   logic [NSTG-1:0]   valid_ff;
   logic              adv;
   logic              out_take;
   out_type           out_ff;
   out_type           skid_ff;
   out_type           fin_word;
   logic              out_v_ff;
   logic              skid_v_ff;

   // one pipeline step, chosen by stage number
   function automatic pipe_type stage_fn(input int unsigned k, input pipe_type p,
                                         input cfg_type cf);
      pipe_type           o;
      logic [9:0]         t1;
      logic [18:0]        t2;
      logic [19:0]        t3;
      logic [17:0]        tr;
      logic signed [10:0] dx;
      logic signed [10:0] dy;
      logic signed [21:0] sdx;
      logic signed [21:0] sdy;
      logic [18:0]        s;
      logic [16:0]        vc;
      logic [32:0]        prod_q;
      logic [61:0]        sqq;
      logic [61:0]        sqv;
      logic signed [5:0]  eq;
      logic signed [5:0]  ev;
      logic signed [21:0] lq;
      logic signed [21:0] lv;
      logic signed [38:0] lpq;
      logic signed [38:0] lpv;
      logic signed [27:0] d;
      logic [3:0]         j0;
      logic [61:0]        ep;
      logic signed [12:0] sh;
      logic [12:0]        nsh;
      logic [50:0]        pw;
      logic [52:0]        t4;
      logic [FAL_W-1:0]   f;
      logic signed [21:0] r;
      o = p;
      if (k >= DIV1_FIRST && k < GEO_STG) begin
         // index / size, restoring, four quotient bits
         for (int i = 0; i < DIV1_PER; i++) begin
            t1    = {o.rem1, o.num[15]};
            o.num = {o.num[14:0], 1'b0};
            if (t1 >= {1'b0, cf.n}) begin
               t1     = t1 - {1'b0, cf.n};
               o.quo1 = {o.quo1[14:0], 1'b1};
            end else begin
               o.quo1 = {o.quo1[14:0], 1'b0};
            end
            o.rem1 = t1[8:0];
         end
      end else if (k == GEO_STG) begin
         // offsets from center and squared distance
         dx    = $signed({1'b0, o.rem1, 1'b0}) - $signed({2'b00, cf.n});
         dy    = $signed({1'b0, o.quo1[8:0], 1'b0}) - $signed({2'b00, cf.n});
         sdx   = dx * dx;
         sdy   = dy * dy;
         s     = 19'(sdx + sdy);
         o.far = (o.quo1 >= {7'b0, cf.n}) || (s >= {1'b0, cf.nsq});
         o.rem2 = o.far ? '0 : s[17:0];
         o.xq   = '0;
         o.root = '0;
         o.rrem = '0;
      end else if (k >= DIV2_FIRST && k < SQRT_FIRST) begin
         // s * 2^32 / size^2, four quotient bits
         for (int i = 0; i < DIV2_PER; i++) begin
            t2 = {o.rem2, 1'b0};
            if (t2 >= {1'b0, cf.nsq}) begin
               t2   = t2 - {1'b0, cf.nsq};
               o.xq = {o.xq[30:0], 1'b1};
            end else begin
               o.xq = {o.xq[30:0], 1'b0};
            end
            o.rem2 = t2[17:0];
         end
      end else if (k >= SQRT_FIRST && k < Q_STG) begin
         // digit-by-digit square root, four root bits
         for (int i = 0; i < SQRT_PER; i++) begin
            t3   = {o.rrem, o.xq[31:30]};
            o.xq = {o.xq[29:0], 2'b00};
            tr   = {o.root, 2'b01};
            if (t3 >= {2'b00, tr}) begin
               t3     = t3 - {2'b00, tr};
               o.root = {o.root[14:0], 1'b1};
            end else begin
               o.root = {o.root[14:0], 1'b0};
            end
            o.rrem = t3[17:0];
         end
      end else if (k == Q_STG) begin
         // base q = b * (1 - v) and the special-case flags
         o.v      = o.far ? '0 : o.root;
         vc       = 17'h10000 - {1'b0, o.v};
         prod_q   = {17'b0, cf.b} * {16'b0, vc};
         o.q      = o.far ? '0 : prod_q[31:12];
         o.a_zero = (cf.a == '0);
         o.f_zero = !o.a_zero && !o.far && (o.v == '0);
         o.q_zero = !o.a_zero && (o.q == '0);
      end else if (k == NORM_STG) begin
         // leading one and mantissa in [1,2) for both logs
         o.pq = '0;
         o.pv = '0;
         for (int i = 0; i < 20; i++) begin
            if (o.q[i]) o.pq = 5'(i);
         end
         for (int i = 0; i < 16; i++) begin
            if (o.v[i]) o.pv = 5'(i);
         end
         o.mq = {11'b0, o.q} << (5'd30 - o.pq);
         o.mv = {15'b0, o.v} << (5'd30 - o.pv);
         o.fq = '0;
         o.fv = '0;
      end else if (k >= LOG_FIRST && k < SCALE_STG) begin
         // one fraction bit of each log by squaring
         sqq  = {31'b0, o.mq} * {31'b0, o.mq};
         sqv  = {31'b0, o.mv} * {31'b0, o.mv};
         o.fq = {o.fq[14:0], sqq[61]};
         o.fv = {o.fv[14:0], sqv[61]};
         o.mq = sqq[61] ? sqq[61:31] : sqq[60:30];
         o.mv = sqv[61] ? sqv[61:31] : sqv[60:30];
      end else if (k == SCALE_STG) begin
         // a * log2, floored to Q.16
         eq   = $signed({1'b0, o.pq}) - 6'sd16;
         ev   = $signed({1'b0, o.pv}) - 6'sd16;
         lq   = $signed({eq, o.fq});
         lv   = $signed({ev, o.fv});
         lpq  = $signed({23'b0, cf.a}) * 39'(lq);
         lpv  = $signed({23'b0, cf.a}) * 39'(lv);
         o.sq = 27'(lpq >>> 12);
         o.sv = 27'(lpv >>> 12);
      end else if (k == D_STG) begin
         // exponent of the ratio, split into integer and fraction
         d     = o.a_zero ? '0 : (28'(o.sq) - 28'(o.sv));
         o.di  = d[27:16];
         o.df  = d[15:0];
         o.big = (o.di >= 12'sd22);
         o.er  = 31'h40000000;
      end else if (k >= EXP_FIRST && k < DEN_STG) begin
         // one 2^(2^-k) factor of the fraction power
         j0 = 4'(k - EXP_FIRST);
         ep = {31'b0, o.er} * {31'b0, EXP_TAB[j0]};
         if (o.df[~j0]) o.er = ep[60:30];
      end else if (k == DEN_STG) begin
         // integer shift of the power and the denominator
         sh  = 13'(o.di) - 13'sd2;
         nsh = -sh;
         if (o.q_zero) begin
            pw = '0;
         end else if (sh >= 13'sd0) begin
            pw = {20'b0, o.er} << sh[4:0];
         end else if (nsh >= 13'd31) begin
            pw = '0;
         end else begin
            pw = {20'b0, o.er >> nsh[4:0]};
         end
         o.den  = {20'b0, cf.c, 16'b0} + {1'b0, pw};
         o.sat  = (o.den <= 52'h1000000);
         o.zero = o.f_zero || (!o.q_zero && o.big);
         o.rem3 = 52'h1000000;
         o.quo3 = '0;
      end else if (k >= DIV3_FIRST && k < FIN_STG) begin
         // 2^44 / den, two quotient bits
         for (int i = 0; i < DIV3_PER; i++) begin
            t4 = {o.rem3, 1'b0};
            if (t4 >= {1'b0, o.den}) begin
               t4     = t4 - {1'b0, o.den};
               o.quo3 = {o.quo3[18:0], 1'b1};
            end else begin
               o.quo3 = {o.quo3[18:0], 1'b0};
            end
            o.rem3 = t4[51:0];
         end
      end else begin
         // falloff select and clamped height
         f      = o.zero ? '0 : (o.sat ? FAL_MAX : o.quo3);
         r      = 22'(o.h) - $signed({2'b00, f});
         o.fval = f;
         if (r < 22'sd0) o.hout = '0;
         else if (r > 22'sd65536) o.hout = 17'h10000;
         else o.hout = r[16:0];
      end
      return o;
   endfunction

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff   <= MAP_SIZE_RST;
         exponent_a_ff <= EXPONENT_A_RST;
         shape_b_ff    <= SHAPE_B_RST;
         scale_c_ff    <= SCALE_C_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAP_SIZE:   map_size_ff   <= csr_wdata[MAP_W-1:0];
            CSR_EXPONENT_A: exponent_a_ff <= csr_wdata;
            CSR_SHAPE_B:    shape_b_ff    <= csr_wdata;
            CSR_SCALE_C:    scale_c_ff    <= csr_wdata;
            default:        map_size_ff   <= map_size_ff;
         endcase
      end
   end

   // effective map size and its square
   assign n_eff = (map_size_ff == '0) ? MAP_W'(1) :
                  ((map_size_ff > N_CAP) ? N_CAP : map_size_ff);
   assign nsq_in = {9'b0, n_eff} * {9'b0, n_eff};

   always_ff @(posedge clock) begin
      nsq_ff <= nsq_in;
   end

   always_comb begin
      cfg.n   = n_eff;
      cfg.nsq = nsq_ff;
      cfg.a   = exponent_a_ff;
      cfg.b   = shape_b_ff;
      cfg.c   = scale_c_ff;
   end

   // entry word
   always_comb begin
      head_in      = '0;
      head_in.num  = req_cell_index;
      head_in.h    = req_height_in;
   end

   for (genvar g = 1; g <= NSTG; g++) begin : g_stage
      assign pipe_in[g] = stage_fn(g, pipe_ff[g-1], cfg);
   end

   // global advance, held only while the skid word waits
   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign out_take  = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0] <= head_in;
         for (int k = 1; k < NSTG; k++) pipe_ff[k] <= pipe_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NSTG-2:0], req_valid};
      end
   end

   always_comb begin
      fin_word.hout = pipe_in[NSTG].hout;
      fin_word.fval = pipe_in[NSTG].fval;
   end

   // output register with one skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= valid_ff[NSTG-1];
         end
      end else if (valid_ff[NSTG-1] && adv) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_ff <= skid_v_ff ? skid_ff : fin_word;
      end else if (adv && !skid_v_ff) begin
         skid_ff <= fin_word;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_height_out    = out_ff.hout;
   assign rsp_falloff_value = out_ff.fval;

   // checks
   `RFHM_ASSERT(a_skid_needs_out, skid_v_ff |-> out_v_ff, "skid word held with empty output")
   `RFHM_ASSERT(a_height_clamped, out_v_ff |-> (out_ff.hout <= 17'h10000), "height above one")
   `RFHM_ASSERT(a_skid_drains, (skid_v_ff && !rsp_stall) |=> !skid_v_ff, "skid word not drained")
   `RFHM_ASSERT_ALWAYS(a_reset_flush, $past(reset) |-> (!out_v_ff && !skid_v_ff), "word after reset")

endmodule
